/* hw/rtl/cbz_pkg.sv */
// ----------------------------------------------------------------------------
// cbz_pkg
// Shared widths and payload types of the cubic Bezier point evaluator.
// ----------------------------------------------------------------------------
package cbz_pkg;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 16;

    // v = 2^F - u needs one extra bit (u == 0 gives v == 2^F)
    localparam int V_BITS    = FRAC_BITS + 1;
    localparam int U3_BITS   = FRAC_BITS + 2;
    localparam int SQ_BITS   = 2 * FRAC_BITS + 2;
    localparam int MUL_BITS  = SQ_BITS + V_BITS;
    // Bernstein weights sum to 2^(3F), so each fits in 3F+1 bits
    localparam int W_BITS    = 3 * FRAC_BITS + 1;
    localparam int PROD_BITS = W_BITS + COORD_BITS;
    localparam int SHIFT     = 3 * FRAC_BITS;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [FRAC_BITS-1:0]  t_frac;
    typedef logic [W_BITS-1:0]     t_weight;

    typedef struct packed {
        t_coord p0_x;
        t_coord p0_y;
        t_coord p1_x;
        t_coord p1_y;
        t_coord p2_x;
        t_coord p2_y;
        t_coord p3_x;
        t_coord p3_y;
        t_frac  param_u;
    } t_in;

    typedef struct packed {
        t_coord curve_x;
        t_coord curve_y;
    } t_out;

    typedef struct packed {
        t_weight w0;
        t_weight w1;
        t_weight w2;
        t_weight w3;
    } t_weights;

endpackage

/* hw/rtl/cbz_weights.sv */
// ----------------------------------------------------------------------------
// cbz_weights
// Three-stage pipeline computing the four cubic Bernstein weights from u.
// The control points ride along unchanged.
// ----------------------------------------------------------------------------
module cbz_weights (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  cbz_pkg::t_in      i_item,
    output logic              o_valid,
    output cbz_pkg::t_weights o_wts,
    output cbz_pkg::t_in      o_item
);

    // stage A: u, v = 2^F - u, 3u
    logic                         r_a_vld;
    cbz_pkg::t_in                 r_a_item;
    logic [cbz_pkg::V_BITS-1:0]   r_a_v;
    logic [cbz_pkg::U3_BITS-1:0]  r_a_u3;
    logic [cbz_pkg::V_BITS-1:0]   n_a_v;
    logic [cbz_pkg::U3_BITS-1:0]  n_a_u3;

    // stage B: v^2, 3uv, 3u^2, u^2
    logic                         r_b_vld;
    cbz_pkg::t_in                 r_b_item;
    logic [cbz_pkg::V_BITS-1:0]   r_b_v;
    logic [cbz_pkg::SQ_BITS-1:0]  r_b_vv;
    logic [cbz_pkg::SQ_BITS-1:0]  r_b_uv3;
    logic [cbz_pkg::SQ_BITS-1:0]  r_b_uu3;
    logic [cbz_pkg::SQ_BITS-1:0]  r_b_uu;
    logic [cbz_pkg::SQ_BITS-1:0]  n_b_vv;
    logic [cbz_pkg::SQ_BITS-1:0]  n_b_uv3;
    logic [cbz_pkg::SQ_BITS-1:0]  n_b_uu3;
    logic [cbz_pkg::SQ_BITS-1:0]  n_b_uu;

    // stage C: weights
    logic                         r_c_vld;
    cbz_pkg::t_in                 r_c_item;
    cbz_pkg::t_weights            r_c_wts;
    cbz_pkg::t_weights            n_c_wts;
    logic [cbz_pkg::MUL_BITS-1:0] m0;
    logic [cbz_pkg::MUL_BITS-1:0] m1;
    logic [cbz_pkg::MUL_BITS-1:0] m2;
    logic [cbz_pkg::MUL_BITS-1:0] m3;

    always_comb begin
        n_a_v  = {1'b1, {cbz_pkg::FRAC_BITS{1'b0}}} - {1'b0, i_item.param_u};
        n_a_u3 = {2'b00, i_item.param_u} + {1'b0, i_item.param_u, 1'b0};
    end

    always_comb begin
        n_b_vv  = cbz_pkg::SQ_BITS'(r_a_v) * cbz_pkg::SQ_BITS'(r_a_v);
        n_b_uv3 = cbz_pkg::SQ_BITS'(r_a_u3) * cbz_pkg::SQ_BITS'(r_a_v);
        n_b_uu3 = cbz_pkg::SQ_BITS'(r_a_u3) * cbz_pkg::SQ_BITS'(r_a_item.param_u);
        n_b_uu  = cbz_pkg::SQ_BITS'(r_a_item.param_u)
                * cbz_pkg::SQ_BITS'(r_a_item.param_u);
    end

    always_comb begin
        m0 = cbz_pkg::MUL_BITS'(r_b_vv)  * cbz_pkg::MUL_BITS'(r_b_v);
        m1 = cbz_pkg::MUL_BITS'(r_b_uv3) * cbz_pkg::MUL_BITS'(r_b_v);
        m2 = cbz_pkg::MUL_BITS'(r_b_uu3) * cbz_pkg::MUL_BITS'(r_b_v);
        m3 = cbz_pkg::MUL_BITS'(r_b_uu)  * cbz_pkg::MUL_BITS'(r_b_item.param_u);
        n_c_wts.w0 = m0[cbz_pkg::W_BITS-1:0];
        n_c_wts.w1 = m1[cbz_pkg::W_BITS-1:0];
        n_c_wts.w2 = m2[cbz_pkg::W_BITS-1:0];
        n_c_wts.w3 = m3[cbz_pkg::W_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_item <= i_item;
        r_a_v    <= n_a_v;
        r_a_u3   <= n_a_u3;

        r_b_item <= r_a_item;
        r_b_v    <= r_a_v;
        r_b_vv   <= n_b_vv;
        r_b_uv3  <= n_b_uv3;
        r_b_uu3  <= n_b_uu3;
        r_b_uu   <= n_b_uu;

        r_c_item <= r_b_item;
        r_c_wts  <= n_c_wts;
    end

    assign o_valid = r_c_vld;
    assign o_wts   = r_c_wts;
    assign o_item  = r_c_item;

endmodule

/* hw/rtl/cbz_axis.sv */
// ----------------------------------------------------------------------------
// cbz_axis
// Three-stage weighted sum of four control coordinates for one axis,
// floored to an integer pixel coordinate.
// ----------------------------------------------------------------------------
module cbz_axis (
    input  logic              i_clk,
    input  cbz_pkg::t_weights i_wts,
    input  cbz_pkg::t_coord   i_q0,
    input  cbz_pkg::t_coord   i_q1,
    input  cbz_pkg::t_coord   i_q2,
    input  cbz_pkg::t_coord   i_q3,
    output cbz_pkg::t_coord   o_coord
);

    logic [cbz_pkg::PROD_BITS-1:0] r_d_p0;
    logic [cbz_pkg::PROD_BITS-1:0] r_d_p1;
    logic [cbz_pkg::PROD_BITS-1:0] r_d_p2;
    logic [cbz_pkg::PROD_BITS-1:0] r_d_p3;
    logic [cbz_pkg::PROD_BITS-1:0] n_d_p0;
    logic [cbz_pkg::PROD_BITS-1:0] n_d_p1;
    logic [cbz_pkg::PROD_BITS-1:0] n_d_p2;
    logic [cbz_pkg::PROD_BITS-1:0] n_d_p3;

    // convex combination: no partial sum can exceed 2^(3F) * max coordinate
    logic [cbz_pkg::PROD_BITS-1:0] r_e_s01;
    logic [cbz_pkg::PROD_BITS-1:0] r_e_s23;
    logic [cbz_pkg::PROD_BITS-1:0] n_f_sum;
    cbz_pkg::t_coord               r_f_coord;

    always_comb begin
        n_d_p0 = cbz_pkg::PROD_BITS'(i_wts.w0) * cbz_pkg::PROD_BITS'(i_q0);
        n_d_p1 = cbz_pkg::PROD_BITS'(i_wts.w1) * cbz_pkg::PROD_BITS'(i_q1);
        n_d_p2 = cbz_pkg::PROD_BITS'(i_wts.w2) * cbz_pkg::PROD_BITS'(i_q2);
        n_d_p3 = cbz_pkg::PROD_BITS'(i_wts.w3) * cbz_pkg::PROD_BITS'(i_q3);
        n_f_sum = r_e_s01 + r_e_s23;
    end

    always_ff @(posedge i_clk) begin
        r_d_p0    <= n_d_p0;
        r_d_p1    <= n_d_p1;
        r_d_p2    <= n_d_p2;
        r_d_p3    <= n_d_p3;
        r_e_s01   <= r_d_p0 + r_d_p1;
        r_e_s23   <= r_d_p2 + r_d_p3;
        // floor: drop the 3F fraction bits
        r_f_coord <= n_f_sum[cbz_pkg::SHIFT +: cbz_pkg::COORD_BITS];
    end

    assign o_coord = r_f_coord;

endmodule

/* hw/rtl/cubic_bezier_point_eval.sv */
// ----------------------------------------------------------------------------
// cubic_bezier_point_eval
// Evaluates one point of a cubic Bezier curve per clock, floored to pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Drive i_item (four control points and u in Q0.16) and raise start. An
//   item transfers at every rising edge with start high and busy low. busy
//   stays low: the six-stage pipeline takes a new item every cycle.
//   Result: o_result (curve_x, curve_y) is shown for one cycle with o_strobe
//   high, once the item has passed the input register and the five register
//   stages after it.
//   Throughput is one point per clock: every stage is registered and nothing
//   loops back. The multiplies are spread over stages: four 17x34 weight
//   multipliers in one stage, four 49x10 coordinate multipliers per axis in
//   the next.
//   Stages: u/v/3u, squares, Bernstein weights, weight*coordinate, pair
//   sums, final sum and floor.
//   Reset (synchronous, active low) clears the valid bits only; items in
//   flight are dropped and no strobe follows until new items are taken.
//   The receiver cannot stall: every result is strobed exactly once.
// ----------------------------------------------------------------------------
module cubic_bezier_point_eval (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  cbz_pkg::t_in    i_item,
    output logic            o_strobe,
    output cbz_pkg::t_out   o_result
);

    logic              w_vld;
    cbz_pkg::t_weights w_wts;
    cbz_pkg::t_in      w_item;
    logic              r_d_vld;
    logic              r_e_vld;
    logic              r_f_vld;

    assign busy = 1'b0;

    cbz_weights u_weights (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_item  (i_item),
        .o_valid (w_vld),
        .o_wts   (w_wts),
        .o_item  (w_item)
    );

    cbz_axis u_axis_x (
        .i_clk   (i_clk),
        .i_wts   (w_wts),
        .i_q0    (w_item.p0_x),
        .i_q1    (w_item.p1_x),
        .i_q2    (w_item.p2_x),
        .i_q3    (w_item.p3_x),
        .o_coord (o_result.curve_x)
    );

    cbz_axis u_axis_y (
        .i_clk   (i_clk),
        .i_wts   (w_wts),
        .i_q0    (w_item.p0_y),
        .i_q1    (w_item.p1_y),
        .i_q2    (w_item.p2_y),
        .i_q3    (w_item.p3_y),
        .o_coord (o_result.curve_y)
    );

    // valid bits for the axis stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else begin
            r_d_vld <= w_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
        end
    end

    assign o_strobe = r_f_vld;

`ifndef ASSERT_OFF
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##6 o_strobe)
        else $error("transfer not followed by result strobe");

    a_u_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.param_u == '0) |-> ##6
        (o_result.curve_x == $past(i_item.p0_x, 6) &&
         o_result.curve_y == $past(i_item.p0_y, 6)))
        else $error("u of zero did not return the first control point");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe)
        else $error("strobe right after reset");
`endif

endmodule
